// ===== sv/serve_from_fullest_pool_unit_assert.svh =====
// Assertion helpers for serve_from_fullest_pool_unit.
// Both sample on clk_i and stay off while rst_ni is low.
`ifndef SERVE_FROM_FULLEST_POOL_UNIT_ASSERT_SVH
`define SERVE_FROM_FULLEST_POOL_UNIT_ASSERT_SVH

// same-cycle implication
`define SFFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sffp_pkg.sv =====
`timescale 1ns / 1ps
package sffp_pkg;

  // item field widths
  localparam int MODE_W     = 1;
  localparam int INDEX_W    = 3;
  localparam int ID_W       = 16;
  localparam int COUNT_W    = 16;
  localparam int AMOUNT_W   = 16;
  localparam int STATUS_W   = 2;

  // register file
  localparam int ACTIVE_W   = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_ACTIVE_ENTRIES = 0;

  // parameter defaults
  localparam int DEF_ENTRIES    = 8;
  localparam int DEF_COUNT_BITS = 16;
  localparam int DEF_ID_BITS    = 16;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_SERVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_LOADED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SERVED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  served_index;
    logic [ID_W-1:0]     served_id;
    logic [COUNT_W-1:0]  remaining_count;
  } res_t;

endpackage

// ===== sv/sffp_if.sv =====
`timescale 1ns / 1ps
interface sffp_in_if import sffp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [INDEX_W-1:0]  entry_index;
  logic [ID_W-1:0]     entry_id;
  logic [COUNT_W-1:0]  entry_count;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, mode, entry_index, entry_id, entry_count, amount,
                  input ready);
  modport sink   (input valid, mode, entry_index, entry_id, entry_count, amount,
                  output ready);
endinterface

interface sffp_out_if import sffp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  served_index;
  logic [ID_W-1:0]     served_id;
  logic [COUNT_W-1:0]  remaining_count;

  modport source (output valid, status, served_index, served_id, remaining_count,
                  input ready);
  modport sink   (input valid, status, served_index, served_id, remaining_count,
                  output ready);
endinterface

// ===== sv/sffp_ram.sv =====
`timescale 1ns / 1ps
module sffp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sffp_apb_regs.sv =====
`timescale 1ns / 1ps
module sffp_apb_regs import sffp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [ACTIVE_W-1:0]   active_entries_o
);

  localparam int REG_IDX_W = APB_ADDR_W - 2;

  logic [ACTIVE_W-1:0] active_q, active_d;
  logic                hit;

  // word-aligned decode, byte offset ignored
  assign hit    = (paddr[APB_ADDR_W-1:2] == REG_IDX_W'(REG_ACTIVE_ENTRIES));
  assign pready = 1'b1;

  always_comb begin
    active_d = active_q;
    if (psel && penable && pwrite && hit) begin
      active_d = pwdata[ACTIVE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else begin
      active_q <= active_d;
    end
  end

  assign prdata           = hit ? APB_DATA_W'(active_q) : '0;
  assign active_entries_o = active_q;

endmodule

// ===== sv/serve_from_fullest_pool_unit.sv =====
`timescale 1ns / 1ps
// serve_from_fullest_pool_unit: table of pools (id + unit count) in one RAM.
// Input channel in_i (valid/ready): mode 0 loads slot entry_index with
// entry_id / entry_count; mode 1 asks for amount units from the pool with
// the largest count among slots 0..active_entries-1 (ties: lowest id, then
// lowest slot). Output channel out_o gives one item per input item: status
// loaded / served / refused, and for a served request the slot, id and
// count left. APB port holds active_entries; a serve clips it to ENTRIES.
// Sequence: a load, or a serve with no active slots, goes from idle to
// the done state, which moves its result into the out_o register.
// A serve reads and compares one slot per cycle on the single RAM read port
// in the scan state, writes the new count back in its decide state when
// served, then passes through the done state to out_o. The next item is
// taken only once the sequencer is back in the idle state.
// in_i.ready is high only when no item is in flight; a finished result
// may still sit in the output register while the next item is accepted.
// If out_o is stalled, the following result waits in the engine, and
// in_i stays low until it has moved to the output register.
// Reset clears control state and active_entries; the table is undefined
// until loaded, and no clearing pass runs.
module serve_from_fullest_pool_unit import sffp_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int ID_BITS    = DEF_ID_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sffp_in_if.sink               in_i,
  sffp_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PTR_W = $clog2(ENTRIES + 1);
  localparam int MEM_W = ID_BITS + COUNT_BITS;
  localparam int CMP_W = (COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [ACTIVE_W-1:0] active_entries;

  sffp_apb_regs u_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .active_entries_o (active_entries)
  );

  // pool table: {id, count} per slot
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [MEM_W-1:0] ram_wdata, ram_rdata;

  sffp_ram #(
    .WIDTH (MEM_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [1:0]            st_q, st_d;
  logic [PTR_W-1:0]      rd_ptr_q, rd_ptr_d;    // next slot to read
  logic [PTR_W-1:0]      cmp_ptr_q, cmp_ptr_d;  // slot whose data is on ram_rdata
  logic [PTR_W-1:0]      n_q, n_d;              // slots to scan
  logic                  out_valid_q, out_valid_d;

  logic [AMOUNT_W-1:0]   amount_q, amount_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [ID_BITS-1:0]    best_id_q, best_id_d;
  logic [COUNT_BITS-1:0] best_cnt_q, best_cnt_d;
  res_t                  res_q, res_d;
  res_t                  out_q, out_d;

  logic                  accept_in, out_free, better, load_in_range;
  logic [PTR_W-1:0]      n_sat;
  logic [ID_BITS-1:0]    rd_id;
  logic [COUNT_BITS-1:0] rd_cnt, new_cnt;

  assign in_i.ready = (st_q == ST_IDLE);
  assign accept_in  = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign load_in_range = (32'(in_i.entry_index) < ENTRIES);
  assign n_sat = (32'(active_entries) > ENTRIES) ? PTR_W'(ENTRIES)
                                                 : PTR_W'(active_entries);

  assign rd_id   = ram_rdata[MEM_W-1:COUNT_BITS];
  assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];
  // first slot seeds the search; strict compare keeps the lowest slot on full ties
  assign better  = (cmp_ptr_q == '0) || (rd_cnt > best_cnt_q) ||
                   ((rd_cnt == best_cnt_q) && (rd_id < best_id_q));
  // exact when the amount fits, i.e. whenever it is used
  assign new_cnt = best_cnt_q - COUNT_BITS'(amount_q);

  always_comb begin
    st_d        = st_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_ptr_d   = cmp_ptr_q;
    n_d         = n_q;
    amount_d    = amount_q;
    best_idx_d  = best_idx_q;
    best_id_d   = best_id_q;
    best_cnt_d  = best_cnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = best_idx_q;
    ram_wdata   = {best_id_q, new_cnt};
    ram_re      = 1'b0;
    ram_raddr   = rd_ptr_q[IDX_W-1:0];

    case (st_q)
      ST_IDLE: begin
        if (accept_in) begin
          res_d = '0;
          if (in_i.mode == MODE_LOAD) begin
            ram_we       = load_in_range;
            ram_waddr    = IDX_W'(in_i.entry_index);
            ram_wdata    = {ID_BITS'(in_i.entry_id), COUNT_BITS'(in_i.entry_count)};
            res_d.status = STATUS_LOADED;
            st_d         = ST_DONE;
          end else begin
            amount_d = in_i.amount;
            n_d      = n_sat;
            if (n_sat == '0) begin
              res_d.status = STATUS_REFUSED;
              st_d         = ST_DONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              rd_ptr_d  = PTR_W'(1);
              cmp_ptr_d = '0;
              st_d      = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (better) begin
          best_idx_d = cmp_ptr_q[IDX_W-1:0];
          best_id_d  = rd_id;
          best_cnt_d = rd_cnt;
        end
        if (rd_ptr_q < n_q) begin
          ram_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + PTR_W'(1);
        end
        if (cmp_ptr_q == n_q - PTR_W'(1)) begin
          st_d = ST_DECIDE;
        end else begin
          cmp_ptr_d = cmp_ptr_q + PTR_W'(1);
        end
      end
      ST_DECIDE: begin
        res_d = '0;
        if (CMP_W'(best_cnt_q) >= CMP_W'(amount_q)) begin
          ram_we                = 1'b1;
          res_d.status          = STATUS_SERVED;
          res_d.served_index    = INDEX_W'(best_idx_q);
          res_d.served_id       = ID_W'(best_id_q);
          res_d.remaining_count = COUNT_W'(new_cnt);
        end else begin
          res_d.status = STATUS_REFUSED;
        end
        st_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      rd_ptr_q    <= '0;
      cmp_ptr_q   <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rd_ptr_q    <= rd_ptr_d;
      cmp_ptr_q   <= cmp_ptr_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amount_q   <= amount_d;
    best_idx_q <= best_idx_d;
    best_id_q  <= best_id_d;
    best_cnt_q <= best_cnt_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_q.status;
  assign out_o.served_index    = out_q.served_index;
  assign out_o.served_id       = out_q.served_id;
  assign out_o.remaining_count = out_q.remaining_count;

`include "serve_from_fullest_pool_unit_assert.svh"

  // table port is never read and written in the same cycle
  `SFFP_ASSERT_NOW(a_no_rw_overlap, ram_we, !ram_re, "table read and write overlap")

  // scan never runs past the active slots
  `SFFP_ASSERT_NOW(a_scan_bound, st_q == ST_SCAN, (cmp_ptr_q < n_q) && (n_q != '0),
                   "scan pointer out of range")

  // loaded and refused results carry zero fields
  `SFFP_ASSERT_NOW(a_zero_fields, out_valid_q && (out_q.status != STATUS_SERVED),
                   (out_q.served_index == '0) && (out_q.served_id == '0) &&
                   (out_q.remaining_count == '0), "non-served result has payload")

  // an accepted item always leaves the idle state
  `SFFP_ASSERT_NEXT(a_accept_busy, accept_in, st_q != ST_IDLE, "accept did not start work")

endmodule
